>>> hdl/swbc_pkg.sv
// ----------------------------------------------------------------------------
// swbc_pkg: shared types and constants of the write-back cache tag store.
// Address split, way and set geometry, access codes and the set row layout.
// ----------------------------------------------------------------------------
package swbc_pkg;

    localparam int ADDR_W      = 32;
    localparam int OFFSET_W    = 6;
    localparam int SET_W       = 9;
    localparam int TAG_W       = ADDR_W - OFFSET_W - SET_W;
    localparam int SET_COUNT   = 1 << SET_W;
    localparam int WAY_COUNT   = 8;
    localparam int WAY_W       = 3;
    localparam int LINE_ADDR_W = 26;
    localparam int COUNT_W     = 32;
    localparam int FUNC_W      = 2;

    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FETCH = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } way_entry_t;

    typedef way_entry_t [WAY_COUNT-1:0] set_row_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic             found_free;
        logic [WAY_W-1:0] victim_way;
    } lookup_t;

endpackage

>>> hdl/set_assoc_writeback_cache_tags.sv
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_tags: tag, valid and dirty store of an 8-way
// write-back data cache with 512 sets of 64-byte lines.
// A read or write reads its set into a register at the accepting edge, then
// compares, updates and writes it back in the lookup state, where the result
// is registered. The input takes no new access until the write-back of the
// previous access is done. An instruction fetch is accepted and gives no
// result. A result held by the output side stalls the input.
// After reset a clearing pass zeroes the set memory, one set per cycle, before
// the first transaction is accepted.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache_tags (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [swbc_pkg::ADDR_W-1:0]         address,
    input  logic [swbc_pkg::FUNC_W-1:0]         func,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic                                evict_dirty,
    output logic [swbc_pkg::LINE_ADDR_W-1:0]    evict_line_address,
    output logic [swbc_pkg::COUNT_W-1:0]        access_count,
    output logic [swbc_pkg::COUNT_W-1:0]        hit_count
);

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_LOOKUP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [swbc_pkg::SET_W-1:0]       clear_idx_reg;
    logic [swbc_pkg::SET_W-1:0]       set_reg;
    logic [swbc_pkg::TAG_W-1:0]       tag_reg;
    logic                             write_reg;
    swbc_pkg::set_row_t               rd_row_reg;
    swbc_pkg::set_row_t               set_mem [swbc_pkg::SET_COUNT];

    logic                             out_valid_reg;
    logic                             hit_reg;
    logic                             evict_dirty_reg;
    logic [swbc_pkg::LINE_ADDR_W-1:0] evict_addr_reg;
    logic [swbc_pkg::COUNT_W-1:0]     access_count_reg;
    logic [swbc_pkg::COUNT_W-1:0]     hit_count_reg;

    logic                             accept;
    logic                             data_access;
    logic                             out_free;
    logic                             complete;
    logic                             mem_we;
    logic [swbc_pkg::SET_W-1:0]       mem_waddr;
    swbc_pkg::set_row_t               mem_wdata;
    swbc_pkg::set_row_t               new_row;
    swbc_pkg::lookup_t                lookup;
    logic                             evict_now;

    swbc_way_sel u_way_sel (
        .row    (rd_row_reg),
        .tag    (tag_reg),
        .result (lookup)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign data_access = !func[1];
    assign out_free    = !out_valid_reg || out_ready;
    assign complete    = (state_reg == S_LOOKUP) && out_free;

    assign evict_now = !lookup.hit && !lookup.found_free &&
                       rd_row_reg[0].valid && rd_row_reg[0].dirty;

    always_comb
    begin
        new_row = rd_row_reg;
        if (lookup.hit)
        begin
            if (write_reg)
            begin
                new_row[lookup.hit_way].dirty = 1'b1;
            end
        end
        else
        begin
            new_row[lookup.victim_way].valid = 1'b1;
            new_row[lookup.victim_way].dirty = write_reg;
            new_row[lookup.victim_way].tag   = tag_reg;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = set_reg;
        mem_wdata = new_row;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_idx_reg;
            mem_wdata = '0;
        end
        else if (complete)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            set_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_row_reg <= set_mem[address[swbc_pkg::OFFSET_W +: swbc_pkg::SET_W]];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clear_idx_reg == swbc_pkg::SET_W'(swbc_pkg::SET_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && data_access)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clear_idx_reg    <= '0;
            out_valid_reg    <= 1'b0;
            access_count_reg <= '0;
            hit_count_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clear_idx_reg <= clear_idx_reg + 1'b1;
            end
            if (complete)
            begin
                out_valid_reg <= 1'b1;
                if (access_count_reg != '1)
                begin
                    access_count_reg <= access_count_reg + 1'b1;
                end
                if (lookup.hit && (hit_count_reg != '1))
                begin
                    hit_count_reg <= hit_count_reg + 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg   <= address[swbc_pkg::OFFSET_W +: swbc_pkg::SET_W];
            tag_reg   <= address[swbc_pkg::OFFSET_W + swbc_pkg::SET_W +: swbc_pkg::TAG_W];
            write_reg <= (func == swbc_pkg::FUNC_WRITE);
        end
        if (complete)
        begin
            hit_reg         <= lookup.hit;
            evict_dirty_reg <= evict_now;
            evict_addr_reg  <= evict_now ? {rd_row_reg[0].tag, set_reg} : '0;
        end
    end

    assign out_valid          = out_valid_reg;
    assign hit                = hit_reg;
    assign evict_dirty        = evict_dirty_reg;
    assign evict_line_address = evict_addr_reg;
    assign access_count       = access_count_reg;
    assign hit_count          = hit_count_reg;

endmodule

>>> hdl/swbc_way_sel.sv
// ----------------------------------------------------------------------------
// swbc_way_sel: way search of one cache set.
// Compares the tag against every valid way, finds the lowest hit way and the
// lowest invalid way, and picks the replacement way for a miss.
// ----------------------------------------------------------------------------
module swbc_way_sel (
    input  swbc_pkg::set_row_t                row,
    input  logic [swbc_pkg::TAG_W-1:0]        tag,
    output swbc_pkg::lookup_t                 result
);

    logic [swbc_pkg::WAY_W-1:0] free_way;

    always_comb
    begin
        result   = '0;
        free_way = '0;
        for (int w = swbc_pkg::WAY_COUNT - 1; w >= 0; w--)
        begin
            if (row[w].valid && (row[w].tag == tag))
            begin
                result.hit     = 1'b1;
                result.hit_way = swbc_pkg::WAY_W'(w);
            end
            if (!row[w].valid)
            begin
                result.found_free = 1'b1;
                free_way          = swbc_pkg::WAY_W'(w);
            end
        end
        // With every way valid, the miss always replaces way 0.
        result.victim_way = result.found_free ? free_way : '0;
    end

endmodule

>>> verif/tb_set_assoc_writeback_cache_tags.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_writeback_cache_tags: self-checking bench for the cache tag store.
// Reads and writes go in through a valid/ready port. A scoreboard keeps its own
// copy of the tags, the valid and dirty bits and the counters, and predicts the
// hit, the dirty eviction and the counts of each access. Every result
// transaction is checked against the oldest prediction. A directed sequence
// covers the corner cases. Random phases then run on small pools of sets and
// tags, so that hits, fills and evictions happen often. Both sides idle at
// random, the output side holds off for a long stretch once, and the input side
// pauses once until every pending result has come.
// ----------------------------------------------------------------------------
module tb_set_assoc_writeback_cache_tags;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 400;
    localparam int PHASES = 8;
    localparam int PHASE_ACCESSES = 212;
    localparam int TAG_POOL = 11;
    localparam int SET_POOL = 4;
    localparam logic [swbc_pkg::FUNC_W-1:0] FUNC_UNDEFINED = 2'd3;

    typedef struct packed {
        logic                             hit;
        logic                             evict_dirty;
        logic [swbc_pkg::LINE_ADDR_W-1:0] evict_line;
        logic [swbc_pkg::COUNT_W-1:0]     accesses;
        logic [swbc_pkg::COUNT_W-1:0]     hits;
    } access_outcome_t;

    class cache_tag_scoreboard;
        logic [swbc_pkg::TAG_W-1:0]   tag_mem [swbc_pkg::SET_COUNT][swbc_pkg::WAY_COUNT];
        bit                           valid_mem [swbc_pkg::SET_COUNT][swbc_pkg::WAY_COUNT];
        bit                           dirty_mem [swbc_pkg::SET_COUNT][swbc_pkg::WAY_COUNT];
        logic [swbc_pkg::COUNT_W-1:0] accesses;
        logic [swbc_pkg::COUNT_W-1:0] hits;
        access_outcome_t              pending [$];
        int                           mismatches;

        function new();
            accesses = '0;
            hits = '0;
            mismatches = 0;
            foreach (valid_mem[s, w])
            begin
                valid_mem[s][w] = 1'b0;
                dirty_mem[s][w] = 1'b0;
                tag_mem[s][w] = '0;
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        function void note_access(logic [swbc_pkg::ADDR_W-1:0] addr,
                                  logic [swbc_pkg::FUNC_W-1:0] code);
            access_outcome_t            outcome;
            logic [swbc_pkg::SET_W-1:0] set_idx;
            logic [swbc_pkg::TAG_W-1:0] line_tag;
            int                         hit_way;
            int                         victim;
            bit                         is_write;
            if (code != swbc_pkg::FUNC_READ && code != swbc_pkg::FUNC_WRITE)
                return;
            is_write = (code == swbc_pkg::FUNC_WRITE);
            outcome = '0;
            set_idx = addr[swbc_pkg::OFFSET_W +: swbc_pkg::SET_W];
            line_tag = addr[swbc_pkg::ADDR_W-1 -: swbc_pkg::TAG_W];
            if (accesses != '1)
                accesses = accesses + 1'b1;
            hit_way = -1;
            for (int w = 0; w < swbc_pkg::WAY_COUNT; w++)
            begin
                if (hit_way < 0 && valid_mem[set_idx][w] && tag_mem[set_idx][w] == line_tag)
                    hit_way = w;
            end
            if (hit_way >= 0)
            begin
                outcome.hit = 1'b1;
                if (is_write)
                    dirty_mem[set_idx][hit_way] = 1'b1;
                if (hits != '1)
                    hits = hits + 1'b1;
            end
            else
            begin
                victim = -1;
                for (int w = 0; w < swbc_pkg::WAY_COUNT; w++)
                begin
                    if (victim < 0 && !valid_mem[set_idx][w])
                        victim = w;
                end
                if (victim < 0)
                begin
                    victim = 0;
                    if (dirty_mem[set_idx][0])
                    begin
                        outcome.evict_dirty = 1'b1;
                        outcome.evict_line = {tag_mem[set_idx][0], set_idx};
                    end
                end
                tag_mem[set_idx][victim] = line_tag;
                valid_mem[set_idx][victim] = 1'b1;
                dirty_mem[set_idx][victim] = is_write;
            end
            outcome.accesses = accesses;
            outcome.hits = hits;
            pending.push_back(outcome);
        endfunction

        task report(string what, logic [swbc_pkg::COUNT_W-1:0] got,
                    logic [swbc_pkg::COUNT_W-1:0] want);
            $display("ERROR: %s: got 0x%0h, expected 0x%0h", what, got, want);
            mismatches++;
        endtask

        task check_result(logic got_hit, logic got_evict,
                          logic [swbc_pkg::LINE_ADDR_W-1:0] got_line,
                          logic [swbc_pkg::COUNT_W-1:0] got_accesses,
                          logic [swbc_pkg::COUNT_W-1:0] got_hits);
            access_outcome_t want;
            if (pending.size() == 0)
            begin
                report("result with no access pending, access_count", got_accesses, '0);
                return;
            end
            want = pending.pop_front();
            if (got_hit !== want.hit)
                report("hit", got_hit, want.hit);
            if (got_evict !== want.evict_dirty)
                report("evict_dirty", got_evict, want.evict_dirty);
            if (got_line !== want.evict_line)
                report("evict_line_address", got_line, want.evict_line);
            if (got_accesses !== want.accesses)
                report("access_count", got_accesses, want.accesses);
            if (got_hits !== want.hits)
                report("hit_count", got_hits, want.hits);
        endtask
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [swbc_pkg::ADDR_W-1:0]      address = '0;
    logic [swbc_pkg::FUNC_W-1:0]      func = swbc_pkg::FUNC_READ;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic                             hit;
    logic                             evict_dirty;
    logic [swbc_pkg::LINE_ADDR_W-1:0] evict_line_address;
    logic [swbc_pkg::COUNT_W-1:0]     access_count;
    logic [swbc_pkg::COUNT_W-1:0]     hit_count;

    cache_tag_scoreboard        sb = new();
    bit                         calm = 1'b0;
    bit                         hold_out_request = 1'b0;
    int                         cycles = 0;
    logic [swbc_pkg::TAG_W-1:0] tag_pool [TAG_POOL];
    logic [swbc_pkg::SET_W-1:0] set_pool [SET_POOL];

    set_assoc_writeback_cache_tags dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .address            (address),
        .func               (func),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .hit                (hit),
        .evict_dirty        (evict_dirty),
        .evict_line_address (evict_line_address),
        .access_count       (access_count),
        .hit_count          (hit_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int pick_gap();
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic logic [swbc_pkg::ADDR_W-1:0] line_address(
        logic [swbc_pkg::TAG_W-1:0] line_tag,
        logic [swbc_pkg::SET_W-1:0] set_idx,
        logic [swbc_pkg::OFFSET_W-1:0] offset);
        return {line_tag, set_idx, offset};
    endfunction

    function automatic logic [swbc_pkg::ADDR_W-1:0] pick_address();
        logic [swbc_pkg::OFFSET_W-1:0] offset;
        offset = swbc_pkg::OFFSET_W'($urandom);
        if ($urandom_range(0, 99) < 12)
            return $urandom;
        return line_address(tag_pool[$urandom_range(0, TAG_POOL - 1)],
                            set_pool[$urandom_range(0, SET_POOL - 1)], offset);
    endfunction

    function automatic logic [swbc_pkg::FUNC_W-1:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return swbc_pkg::FUNC_READ;
        if (r < 90)
            return swbc_pkg::FUNC_WRITE;
        if (r < 96)
            return swbc_pkg::FUNC_FETCH;
        return FUNC_UNDEFINED;
    endfunction

    task automatic send_access(logic [swbc_pkg::ADDR_W-1:0] addr,
                               logic [swbc_pkg::FUNC_W-1:0] code);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        address <= addr;
        func <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_access(addr, code);
    endtask

    initial
    begin
        int stall;
        forever
        begin
            stall = pick_gap();
            if (hold_out_request)
            begin
                stall = LONG_HOLD;
                hold_out_request = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_result(hit, evict_dirty, evict_line_address, access_count, hit_count);
        end
    end

    initial
    begin
        logic [swbc_pkg::ADDR_W-1:0] addr;
        logic [swbc_pkg::FUNC_W-1:0] code;
        int                          data_accesses;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_access(32'hFFFF_FFFF, FUNC_UNDEFINED);
        send_access(32'h0000_0000, swbc_pkg::FUNC_FETCH);
        send_access(32'h0000_0000, swbc_pkg::FUNC_READ);
        send_access(32'h0000_003F, swbc_pkg::FUNC_READ);
        send_access(32'h0000_0000, swbc_pkg::FUNC_WRITE);
        send_access(32'hFFFF_FFFF, swbc_pkg::FUNC_WRITE);
        for (int t = 1; t < swbc_pkg::WAY_COUNT; t++)
            send_access(line_address(swbc_pkg::TAG_W'(t), '1, swbc_pkg::OFFSET_W'(t * 9)),
                        swbc_pkg::FUNC_WRITE);
        send_access(line_address(swbc_pkg::TAG_W'(8), '1, '0), swbc_pkg::FUNC_READ);
        send_access(line_address(swbc_pkg::TAG_W'(9), '1, '1), swbc_pkg::FUNC_READ);
        send_access(line_address(swbc_pkg::TAG_W'(3), '1, '0), swbc_pkg::FUNC_WRITE);
        send_access(32'hFFFF_FFC0, swbc_pkg::FUNC_READ);
        send_access(line_address(swbc_pkg::TAG_W'(3), '1, '0), swbc_pkg::FUNC_FETCH);
        send_access(line_address(swbc_pkg::TAG_W'(1), '1, '1), swbc_pkg::FUNC_READ);
        send_access(line_address(swbc_pkg::TAG_W'(10), '1, '0), swbc_pkg::FUNC_WRITE);
        send_access(line_address(swbc_pkg::TAG_W'(11), '1, '0), swbc_pkg::FUNC_READ);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            calm = (phase == 3);
            foreach (tag_pool[i])
                tag_pool[i] = swbc_pkg::TAG_W'($urandom);
            foreach (set_pool[i])
                set_pool[i] = swbc_pkg::SET_W'($urandom);
            if (phase == 2)
                hold_out_request = 1'b1;
            data_accesses = 0;
            while (data_accesses < PHASE_ACCESSES)
            begin
                addr = pick_address();
                code = pick_func();
                send_access(addr, code);
                if (code == swbc_pkg::FUNC_READ || code == swbc_pkg::FUNC_WRITE)
                    data_accesses++;
            end
            if (phase == 4)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (sb.outstanding() != 0);
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
